// ===== src/software_timer_bank_defines.svh =====
// Assertion macros shared by the timer bank RTL.
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define STB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stb_pkg.sv =====
`timescale 1ns / 1ps

package stb_pkg;

    localparam int MASK_W = 8;
    localparam int IDX_W  = 3;
    localparam int LOAD_W = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ARM   = 2'd1,
        OP_STOP  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_RUN   = 2'd1,
        PH_START = 2'd2,
        PH_RESET = 2'd3
    } t_phase;

    // Per-timer command strobes, at most one set at a time.
    typedef struct packed {
        logic do_tick;
        logic do_arm;
        logic do_stop;
        logic do_reset;
    } t_timer_cmd;

endpackage

// ===== src/stb_timer.sv =====
`timescale 1ns / 1ps

module stb_timer #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stb_pkg::t_timer_cmd   i_cmd,
    input  logic [COUNT_BITS-1:0] i_load,
    input  logic                  i_repeat,
    output logic                  o_expired,
    output logic                  o_running
);
    import stb_pkg::*;

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_reload, n_reload;
    logic                  r_repeat, n_repeat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_STOP;
            r_count  <= '0;
            r_reload <= '0;
            r_repeat <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_reload <= n_reload;
            r_repeat <= n_repeat;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_reload  = r_reload;
        n_repeat  = r_repeat;
        o_expired = 1'b0;
        priority if (i_cmd.do_tick) begin
            unique case (r_phase)
                PH_RUN: begin
                    if (r_count == '0) begin
                        o_expired = 1'b1;
                        if (r_repeat) begin
                            n_count = r_reload;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                PH_START: begin
                    n_count = r_reload;
                    n_phase = PH_RUN;
                end
                PH_RESET: n_phase = PH_START;
                PH_STOP:  n_phase = PH_STOP;
                default:  n_phase = r_phase;
            endcase
        end else if (i_cmd.do_arm) begin
            n_reload = i_load;
            n_repeat = i_repeat;
            n_phase  = PH_START;
        end else if (i_cmd.do_stop) begin
            n_phase = PH_STOP;   // count is kept
        end else if (i_cmd.do_reset) begin
            n_phase = PH_RESET;
        end else begin
            n_phase = r_phase;   // no command: hold
        end
    end

    // Phase after this step.
    assign o_running = (n_phase == PH_RUN);

endmodule

// ===== src/software_timer_bank.sv =====
`timescale 1ns / 1ps
// Software timer bank: NUM_TIMERS down-counting timers, one request at a time.
// Input channel: a request (i_op, i_timer_index, i_load_value, i_repeat_flag)
// is taken at a rising edge with start high and busy low. busy stays low, so
// a request can be issued every cycle.
//   tick  - every timer steps at once (expire/reload, decrement, load, ...)
//   arm   - write reload and repeat, timer goes start pending
//   stop  - timer stops, count is kept
//   reset - timer goes reset pending, runs two ticks later
// Commands aimed at an index at or above NUM_TIMERS change nothing but still
// return a result.
// Result channel: one result per request, shown for one cycle with o_strobe.
// o_expired_mask flags timers that expired on a tick (zero for commands),
// o_running_mask flags timers running after the step; timers past bit 7 are
// not reported. The receiver cannot stall.
// Timing: request register, one pass of per-timer logic into the timer state
// and the result register; o_strobe and both masks are driven from the result
// register, which is loaded from the request register. One request per cycle.
// Reset (i_rst_n, synchronous, active low): all timers stopped, counts, reload
// values and repeat flags zero; no result is pending.

module software_timer_bank #(
    parameter int NUM_TIMERS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_op,
    input  logic [stb_pkg::IDX_W-1:0]  i_timer_index,
    input  logic [stb_pkg::LOAD_W-1:0] i_load_value,
    input  logic                       i_repeat_flag,
    output logic                       o_strobe,
    output logic [stb_pkg::MASK_W-1:0] o_expired_mask,
    output logic [stb_pkg::MASK_W-1:0] o_running_mask
);
    import stb_pkg::*;

    // request register
    logic                  r_req_vld, n_req_vld;
    t_op                   r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [COUNT_BITS-1:0] r_load;
    logic                  r_rep;

    // result register
    logic                  r_strobe;
    logic [MASK_W-1:0]     r_expired, n_expired;
    logic [MASK_W-1:0]     r_running, n_running;

    logic [NUM_TIMERS-1:0] w_exp;
    logic [NUM_TIMERS-1:0] w_run;

    assign busy      = 1'b0;
    assign n_req_vld = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_req_vld <= n_req_vld;
            r_strobe  <= r_req_vld;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (n_req_vld) begin
            r_op   <= t_op'(i_op);
            r_idx  <= i_timer_index;
            r_load <= COUNT_BITS'(i_load_value);   // keep low COUNT_BITS bits
            r_rep  <= i_repeat_flag;
        end
        r_expired <= n_expired;
        r_running <= n_running;
    end

    // One cell per timer; every cell sees a tick, only the addressed one sees arm, stop or reset.
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
        logic       w_sel;
        t_timer_cmd w_cmd;

        assign w_sel          = (32'(r_idx) == g);
        assign w_cmd.do_tick  = r_req_vld && (r_op == OP_TICK);
        assign w_cmd.do_arm   = r_req_vld && (r_op == OP_ARM)   && w_sel;
        assign w_cmd.do_stop  = r_req_vld && (r_op == OP_STOP)  && w_sel;
        assign w_cmd.do_reset = r_req_vld && (r_op == OP_RESET) && w_sel;

        stb_timer #(
            .COUNT_BITS(COUNT_BITS)
        ) u_timer (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (w_cmd),
            .i_load   (r_load),
            .i_repeat (r_rep),
            .o_expired(w_exp[g]),
            .o_running(w_run[g])
        );
    end

    // Fit the bank onto the 8-bit masks: drop upper timers, pad small banks.
    for (genvar k = 0; k < MASK_W; k++) begin : g_mask
        if (k < NUM_TIMERS) begin : g_used
            assign n_expired[k] = w_exp[k];
            assign n_running[k] = w_run[k];
        end else begin : g_pad
            assign n_expired[k] = 1'b0;
            assign n_running[k] = 1'b0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_expired_mask = r_expired;
    assign o_running_mask = r_running;

`include "software_timer_bank_defines.svh"

    // every registered request yields exactly one result next cycle
    `STB_ASSERT_NEXT(a_req_to_result, i_clk, i_rst_n, r_req_vld, o_strobe,
        "request did not produce a result")
    // expiries are reported only for tick requests
    `STB_ASSERT_IMPL(a_expire_on_tick, i_clk, i_rst_n,
        o_strobe && (o_expired_mask != '0), $past(r_op) == OP_TICK,
        "expiry reported on a command request")
    // a strobe is always backed by a request in the previous cycle
    `STB_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(r_req_vld),
        "result without a request")

endmodule

// ===== sim/tb_software_timer_bank.sv =====
`timescale 1ns / 1ps

module tb_software_timer_bank;
    import stb_pkg::*;

    localparam int NUM_T       = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [MASK_W-1:0] expired;
        logic [MASK_W-1:0] running;
    } t_masks;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_op = OP_TICK;
    logic [IDX_W-1:0]   i_timer_index = '0;
    logic [LOAD_W-1:0]  i_load_value = '0;
    logic               i_repeat_flag = 1'b0;
    logic               o_strobe;
    logic [MASK_W-1:0]  o_expired_mask;
    logic [MASK_W-1:0]  o_running_mask;

    // Shadow copy of the timer bank, advanced once per accepted request.
    t_phase             tmr_phase  [NUM_T];
    logic [LOAD_W-1:0]  tmr_count  [NUM_T];
    logic [LOAD_W-1:0]  tmr_reload [NUM_T];
    logic               tmr_rep    [NUM_T];

    t_masks pending_masks[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     idle_odds = 0;      // percent chance of a gap before each request

    software_timer_bank #(
        .NUM_TIMERS(NUM_T),
        .COUNT_BITS(LOAD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_timer_index  (i_timer_index),
        .i_load_value   (i_load_value),
        .i_repeat_flag  (i_repeat_flag),
        .o_strobe       (o_strobe),
        .o_expired_mask (o_expired_mask),
        .o_running_mask (o_running_mask)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_bank();
        for (int i = 0; i < NUM_T; i++) begin
            tmr_phase[i]  = PH_STOP;
            tmr_count[i]  = '0;
            tmr_reload[i] = '0;
            tmr_rep[i]    = 1'b0;
        end
    endfunction

    function automatic t_masks timer_bank_step(t_op op, logic [IDX_W-1:0] idx,
                                               logic [LOAD_W-1:0] ld, logic rep);
        t_masks m;
        m = '0;
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM_T; i++) begin
                case (tmr_phase[i])
                    PH_RUN: begin
                        // zero count expires; repeaters reload, others stop
                        if (tmr_count[i] == '0) begin
                            if (tmr_rep[i])
                                tmr_count[i] = tmr_reload[i];
                            else
                                tmr_phase[i] = PH_STOP;
                            if (i < MASK_W)
                                m.expired[i] = 1'b1;
                        end else begin
                            tmr_count[i] = tmr_count[i] - 1'b1;
                        end
                    end
                    PH_START: begin
                        tmr_count[i] = tmr_reload[i];
                        tmr_phase[i] = PH_RUN;
                    end
                    PH_RESET: tmr_phase[i] = PH_START;
                    default: ;
                endcase
            end
        end else if (int'(idx) < NUM_T) begin
            case (op)
                OP_ARM: begin
                    tmr_reload[idx] = ld;
                    tmr_rep[idx]    = rep;
                    tmr_phase[idx]  = PH_START;
                end
                OP_STOP:  tmr_phase[idx] = PH_STOP;
                OP_RESET: tmr_phase[idx] = PH_RESET;
                default: ;
            endcase
        end
        for (int i = 0; i < NUM_T && i < MASK_W; i++)
            m.running[i] = (tmr_phase[i] == PH_RUN);
        return m;
    endfunction

    // ------------------------------------------------------------------ checker

    task automatic report_mismatch(string what, logic [MASK_W-1:0] got,
                                   logic [MASK_W-1:0] want);
        $display("[%0t] mismatch %s: got %02h, want %02h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Outputs sampled at the edge that ends the strobe cycle (pre-update values).
    always @(posedge i_clk) begin
        t_masks want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_masks.size() == 0) begin
                report_mismatch("unexpected result", o_running_mask, '0);
            end else begin
                want = pending_masks.pop_front();
                if (o_expired_mask !== want.expired)
                    report_mismatch("expired_mask", o_expired_mask, want.expired);
                if (o_running_mask !== want.running)
                    report_mismatch("running_mask", o_running_mask, want.running);
            end
        end
    end

    // ------------------------------------------------------------------ driving

    // Drops start and lets the requested number of rising edges pass.
    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Holds the sender until every outstanding result has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_masks.size() != 0);
    endtask

    // Start stays high on return so back-to-back requests need no re-raise.
    task automatic issue_request(t_op op, logic [IDX_W-1:0] idx,
                                 logic [LOAD_W-1:0] ld, logic rep);
        if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds)
            hold_off($urandom_range(1, 9));
        start         <= 1'b1;
        i_op          <= op;
        i_timer_index <= idx;
        i_load_value  <= ld;
        i_repeat_flag <= rep;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_masks.push_back(timer_bank_step(op, idx, ld, rep));
    endtask

    // Mostly short reloads so that expiries are frequent.
    function automatic logic [LOAD_W-1:0] rand_load();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 15)
            return LOAD_W'($urandom_range(0, 7));
        else if (pick < 18)
            return LOAD_W'($urandom_range(0, 255));
        else
            return LOAD_W'($urandom);
    endfunction

    task automatic issue_random_request();
        int pick;
        t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            op = OP_TICK;
        else if (pick < 75)
            op = OP_ARM;
        else if (pick < 85)
            op = OP_STOP;
        else
            op = OP_RESET;
        issue_request(op, IDX_W'($urandom), rand_load(), 1'($urandom));
    endtask

    // -------------------------------------------------------------------- tests

    task automatic test_idle_bank();
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK, 3'd7, 16'hFFFF, 1'b1);
    endtask

    task automatic test_directed_commands();
        // zero reload with repeat: expires on every tick after the first
        issue_request(OP_ARM,  3'd0, 16'h0000, 1'b1);
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        // largest reload, one-shot; never reaches zero here
        issue_request(OP_ARM,  3'd7, 16'hFFFF, 1'b0);
        // one-shot of one: two ticks of count then expiry and stop
        issue_request(OP_ARM,  3'd3, 16'h0001, 1'b0);
        issue_request(OP_TICK, 3'd5, 16'h1234, 1'b1);
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK, 3'd0, 16'h0000, 1'b0);
        // reset of a stopped timer: start pending after one tick, running after two
        issue_request(OP_RESET, 3'd5, 16'hAAAA, 1'b1);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        // stop keeps the count; reset of a running timer restarts it
        issue_request(OP_STOP,  3'd7, 16'h5555, 1'b1);
        issue_request(OP_RESET, 3'd0, 16'h0000, 1'b0);
        issue_request(OP_STOP,  3'd2, 16'h0000, 1'b0);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        issue_request(OP_ARM,   3'd1, 16'h8000, 1'b1);
        issue_request(OP_ARM,   3'd0, 16'h0002, 1'b0);
        issue_request(OP_RESET, 3'd7, 16'h0000, 1'b0);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        issue_request(OP_TICK,  3'd0, 16'h0000, 1'b0);
        issue_request(OP_STOP,  3'd0, 16'h0000, 1'b0);
    endtask

    // Arm a few timers, then run a stretch of ticks, with occasional interference.
    task automatic test_armed_sequences(int rounds);
        for (int r = 0; r < rounds; r++) begin
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            repeat ($urandom_range(1, 3))
                issue_request(OP_ARM, IDX_W'($urandom), LOAD_W'($urandom_range(0, 6)),
                              1'($urandom));
            repeat ($urandom_range(3, 12)) begin
                if ($urandom_range(0, 9) == 0)
                    issue_random_request();
                else
                    issue_request(OP_TICK, IDX_W'($urandom), LOAD_W'($urandom),
                                  1'($urandom));
            end
        end
    endtask

    task automatic test_random_mix(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0)
                idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            issue_random_request();
        end
    endtask

    task automatic test_back_to_back(int count);
        idle_odds = 0;
        repeat (count) issue_random_request();
    endtask

    initial begin
        clear_bank();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bank();
        test_directed_commands();
        wait_for_results();
        test_armed_sequences(40);
        wait_for_results();
        test_random_mix(650);
        wait_for_results();
        test_back_to_back(300);

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_masks.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
